// ===== sv/tbv_pkg.sv =====
// Shared types, constants and rounding helper for the tangent basis pipeline.
`timescale 1ns / 1ps

package tbv_pkg;

    // Fixed-point constants.
    localparam logic [31:0]        Q30_ONE_U    = 32'h4000_0000;
    localparam logic signed [31:0] Q30_ONE_S    = 32'sh4000_0000;
    localparam logic [31:0]        HELPER_LIMIT = 32'd966367642;
    localparam logic signed [63:0] Q60_ONE      = 64'sh1000_0000_0000_0000;
    localparam logic [63:0]        Q30_HALF     = 64'h0000_0000_2000_0000;

    // Pipeline geometry of the normalizer.
    localparam int ROOT_W = 32;          // bits of floor(sqrt(sum of squares))
    localparam int QUO_W  = 31;          // bits of each normalized quotient
    localparam int DIVD_W = 62;          // bits of each dividend
    localparam int VEC_W  = 96;          // three packed 32-bit components

    // Input beat.
    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic signed [31:0] b1_x;
        logic signed [31:0] b1_y;
        logic signed [31:0] b1_z;
        logic signed [31:0] b2_x;
        logic signed [31:0] b2_y;
        logic signed [31:0] b2_z;
    } t_out;

    // Sign and magnitude of one component.
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } t_sm;

    // Pipeline advance and the valid bit entering a unit.
    typedef struct packed {
        logic en;
        logic vld;
    } t_flow;

    // Reduces a Q4.60 value to Q2.30, rounding half away from zero.
    function automatic t_sm round_q30(input logic signed [63:0] p);
        logic [63:0] m;
        logic [63:0] r;
        t_sm         res;
        m       = p[63] ? (~p + 64'd1) : p;
        r       = (m + Q30_HALF) >> 30;
        res.neg = p[63];
        res.mag = r[31:0];
        return res;
    endfunction

endpackage

// ===== sv/tbv_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps

module tbv_sqrt #(
    parameter int SB_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbv_pkg::t_flow       i_flow,
    input  logic [63:0]          i_s,
    input  logic [SB_W-1:0]      i_sb,
    output logic                 o_vld,
    output logic [31:0]          o_root,
    output logic [SB_W-1:0]      o_sb
);
    import tbv_pkg::*;

    localparam int STG = ROOT_W;

    logic [63:0]     r_rem [0:STG-1];
    logic [31:0]     r_q   [0:STG-1];
    logic [SB_W-1:0] r_sb  [0:STG-1];
    logic            r_vld [0:STG-1];

    for (genvar j = 0; j < STG; j++) begin : g_stg
        localparam int B = STG - 1 - j;
        logic [63:0]     rem_prev;
        logic [31:0]     q_prev;
        logic [SB_W-1:0] sb_prev;
        logic            vld_prev;
        logic [65:0]     trial;
        logic            ge;
        logic [63:0]     n_rem;
        logic [31:0]     n_q;

        if (j == 0) begin : g_head
            assign rem_prev = i_s;
            assign q_prev   = '0;
            assign sb_prev  = i_sb;
            assign vld_prev = i_flow.vld;
        end else begin : g_body
            assign rem_prev = r_rem[j-1];
            assign q_prev   = r_q[j-1];
            assign sb_prev  = r_sb[j-1];
            assign vld_prev = r_vld[j-1];
        end

        // Setting bit B grows the square by 2*q*2^B + 2^(2B).
        always_comb begin
            trial  = ({34'b0, q_prev} << (B + 1)) + (66'd1 << (2 * B));
            ge     = ({2'b0, rem_prev} >= trial);
            n_rem  = ge ? (rem_prev - trial[63:0]) : rem_prev;
            n_q    = q_prev;
            n_q[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_flow.en) begin
                r_vld[j] <= vld_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_flow.en) begin
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
                r_sb[j]  <= sb_prev;
            end
        end
    end

    assign o_vld  = r_vld[STG-1];
    assign o_root = r_q[STG-1];
    assign o_sb   = r_sb[STG-1];

endmodule

// ===== sv/tbv_div.sv =====
// Three-lane pipelined restoring divider with a shared divisor.
`timescale 1ns / 1ps

module tbv_div #(
    parameter int SB_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tbv_pkg::t_flow               i_flow,
    input  logic [31:0]                  i_n,
    input  logic [2:0][tbv_pkg::DIVD_W-1:0] i_d,
    input  logic [SB_W-1:0]              i_sb,
    output logic                         o_vld,
    output logic [2:0][tbv_pkg::QUO_W-1:0]  o_q,
    output logic [SB_W-1:0]              o_sb
);
    import tbv_pkg::*;

    localparam int STG = QUO_W;

    logic [2:0][DIVD_W-1:0] r_rem [0:STG-1];
    logic [2:0][QUO_W-1:0]  r_q   [0:STG-1];
    logic [31:0]            r_n   [0:STG-1];
    logic [SB_W-1:0]        r_sb  [0:STG-1];
    logic                   r_vld [0:STG-1];

    for (genvar j = 0; j < STG; j++) begin : g_stg
        localparam int B = STG - 1 - j;
        logic [2:0][DIVD_W-1:0] rem_prev;
        logic [2:0][QUO_W-1:0]  q_prev;
        logic [31:0]            n_prev;
        logic [SB_W-1:0]        sb_prev;
        logic                   vld_prev;
        logic [DIVD_W-1:0]      dv;
        logic [2:0][DIVD_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0]  n_q;

        if (j == 0) begin : g_head
            assign rem_prev = i_d;
            assign q_prev   = '0;
            assign n_prev   = i_n;
            assign sb_prev  = i_sb;
            assign vld_prev = i_flow.vld;
        end else begin : g_body
            assign rem_prev = r_rem[j-1];
            assign q_prev   = r_q[j-1];
            assign n_prev   = r_n[j-1];
            assign sb_prev  = r_sb[j-1];
            assign vld_prev = r_vld[j-1];
        end

        always_comb begin
            dv = {{(DIVD_W-32){1'b0}}, n_prev} << B;
            for (int l = 0; l < 3; l++) begin
                n_q[l] = q_prev[l];
                if (rem_prev[l] >= dv) begin
                    n_rem[l]  = rem_prev[l] - dv;
                    n_q[l][B] = 1'b1;
                end else begin
                    n_rem[l]  = rem_prev[l];
                    n_q[l][B] = 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_flow.en) begin
                r_vld[j] <= vld_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_flow.en) begin
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
                r_n[j]   <= n_prev;
                r_sb[j]  <= sb_prev;
            end
        end
    end

    assign o_vld = r_vld[STG-1];
    assign o_q   = r_q[STG-1];
    assign o_sb  = r_sb[STG-1];

endmodule

// ===== sv/tbv_unitize.sv =====
// Vector normalizer: block scaling, sum of squares, square root and division.
`timescale 1ns / 1ps

module tbv_unitize #(
    parameter int TAG_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tbv_pkg::t_flow         i_flow,
    input  tbv_pkg::t_sm [2:0]     i_v,
    input  logic [TAG_W-1:0]       i_tag,
    output logic                   o_vld,
    output logic [2:0][31:0]       o_u,
    output logic [TAG_W-1:0]       o_tag
);
    import tbv_pkg::*;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic             zero;
    } t_ssb;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [2:0]       neg;
        logic             zero;
    } t_dsb;

    // Stage 0: split and find the largest magnitude.
    logic [2:0][31:0] r0_mag;
    logic [2:0]       r0_neg;
    logic [31:0]      r0_max;
    logic [TAG_W-1:0] r0_tag;
    logic             r0_vld;
    logic [31:0]      n_max01;
    logic [31:0]      n_max;

    always_comb begin
        n_max01 = (i_v[0].mag > i_v[1].mag) ? i_v[0].mag : i_v[1].mag;
        n_max   = (n_max01 > i_v[2].mag) ? n_max01 : i_v[2].mag;
    end

    // Stage 1: shift that brings the largest magnitude into [2^30, 2^31].
    logic [2:0][31:0] r1_mag;
    logic [2:0]       r1_neg;
    logic [4:0]       r1_sh;
    logic             r1_zero;
    logic [TAG_W-1:0] r1_tag;
    logic             r1_vld;
    logic [4:0]       n_sh;

    always_comb begin
        n_sh = '0;
        for (int i = 0; i < 30; i++) begin
            if (r0_max[i]) begin
                n_sh = 5'(30 - i);
            end
        end
        if (r0_max[31] || r0_max[30]) begin
            n_sh = '0;
        end
    end

    // Stage 2: scaled magnitudes. Stage 3: squares. Stage 4: their sum.
    logic [2:0][31:0] r2_mag;
    logic [2:0]       r2_neg;
    logic             r2_zero;
    logic [TAG_W-1:0] r2_tag;
    logic             r2_vld;

    logic [2:0][63:0] r3_sq;
    logic [2:0][31:0] r3_mag;
    logic [2:0]       r3_neg;
    logic             r3_zero;
    logic [TAG_W-1:0] r3_tag;
    logic             r3_vld;
    logic [2:0][63:0] n_sq;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = r2_mag[i] * r2_mag[i];
        end
    end

    logic [63:0]      r4_s;
    t_ssb             r4_sb;
    logic             r4_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_flow.en) begin
            r0_vld <= i_flow.vld;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            for (int i = 0; i < 3; i++) begin
                r0_mag[i] <= i_v[i].mag;
                r0_neg[i] <= i_v[i].neg;
                r2_mag[i] <= r1_mag[i] << r1_sh;
            end
            r0_max     <= n_max;
            r0_tag     <= i_tag;
            r1_mag     <= r0_mag;
            r1_neg     <= r0_neg;
            r1_sh      <= n_sh;
            r1_zero    <= (r0_max == 32'd0);
            r1_tag     <= r0_tag;
            r2_neg     <= r1_neg;
            r2_zero    <= r1_zero;
            r2_tag     <= r1_tag;
            r3_sq      <= n_sq;
            r3_mag     <= r2_mag;
            r3_neg     <= r2_neg;
            r3_zero    <= r2_zero;
            r3_tag     <= r2_tag;
            r4_s       <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            r4_sb.tag  <= r3_tag;
            r4_sb.neg  <= r3_neg;
            r4_sb.mag  <= r3_mag;
            r4_sb.zero <= r3_zero;
        end
    end

    // Square root.
    logic        sq_vld;
    logic [31:0] sq_root;
    t_ssb        sq_sb;

    tbv_sqrt #(
        .SB_W ($bits(t_ssb))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{en: i_flow.en, vld: r4_vld}),
        .i_s     (r4_s),
        .i_sb    (r4_sb),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    // Stage 5: rounded dividends mag * 2^30 + n / 2.
    logic [2:0][DIVD_W-1:0] r5_d;
    logic [31:0]            r5_n;
    t_dsb                   r5_sb;
    logic                   r5_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_flow.en) begin
            r5_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            for (int i = 0; i < 3; i++) begin
                r5_d[i] <= {sq_sb.mag[i], 30'b0} + {31'b0, sq_root[31:1]};
            end
            r5_n       <= sq_root;
            r5_sb.tag  <= sq_sb.tag;
            r5_sb.neg  <= sq_sb.neg;
            r5_sb.zero <= sq_sb.zero;
        end
    end

    // Division.
    logic                  dv_vld;
    logic [2:0][QUO_W-1:0] dv_q;
    t_dsb                  dv_sb;

    tbv_div #(
        .SB_W ($bits(t_dsb))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{en: i_flow.en, vld: r5_vld}),
        .i_n     (r5_n),
        .i_d     (r5_d),
        .i_sb    (r5_sb),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_sb    (dv_sb)
    );

    // Stage 6: limit to one, restore signs, force zero vectors to zero.
    logic [2:0][31:0] r6_u;
    logic [TAG_W-1:0] r6_tag;
    logic             r6_vld;
    logic [2:0][31:0] n_u;
    logic [31:0]      n_val;

    always_comb begin
        n_val = '0;
        for (int i = 0; i < 3; i++) begin
            n_val = ({1'b0, dv_q[i]} > Q30_ONE_U) ? Q30_ONE_U : {1'b0, dv_q[i]};
            if (dv_sb.zero) begin
                n_u[i] = '0;
            end else if (dv_sb.neg[i]) begin
                n_u[i] = ~n_val + 32'd1;
            end else begin
                n_u[i] = n_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_flow.en) begin
            r6_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            r6_u   <= n_u;
            r6_tag <= dv_sb.tag;
        end
    end

    assign o_vld = r6_vld;
    assign o_u   = r6_u;
    assign o_tag = r6_tag;

endmodule

// ===== sv/tbv_gs.sv =====
// Helper-axis choice and Gram-Schmidt step, three register stages.
`timescale 1ns / 1ps

module tbv_gs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbv_pkg::t_flow     i_flow,
    input  logic [2:0][31:0]   i_e,
    output logic               o_vld,
    output tbv_pkg::t_sm [2:0] o_t,
    output logic [2:0][31:0]   o_e
);
    import tbv_pkg::*;

    logic [2:0][31:0] r0_e;
    logic [31:0]      r0_ek;
    logic             r0_k;
    logic             r0_vld;
    logic [31:0]      n_ex;
    logic             n_k;

    // The y axis is the helper when |E.x| reaches the limit.
    always_comb begin
        n_ex = i_e[0][31] ? (~i_e[0] + 32'd1) : i_e[0];
        n_k  = (n_ex >= HELPER_LIMIT);
    end

    logic signed [2:0][63:0] r1_p;
    logic [2:0][31:0]        r1_e;
    logic                    r1_k;
    logic                    r1_vld;
    logic signed [2:0][63:0] n_p;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p[i] = $signed(r0_ek) * $signed(r0_e[i]);
        end
    end

    t_sm [2:0]        r2_t;
    logic [2:0][31:0] r2_e;
    logic             r2_vld;
    t_sm [2:0]        n_t;
    logic signed [63:0] n_diff;

    always_comb begin
        n_diff = '0;
        for (int i = 0; i < 3; i++) begin
            if ((i == 0 && !r1_k) || (i == 1 && r1_k)) begin
                n_diff = Q60_ONE - r1_p[i];
            end else begin
                n_diff = 64'sd0 - r1_p[i];
            end
            n_t[i] = round_q30(n_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_flow.en) begin
            r0_vld <= i_flow.vld;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            r0_e  <= i_e;
            r0_k  <= n_k;
            r0_ek <= n_k ? i_e[1] : i_e[0];
            r1_p  <= n_p;
            r1_e  <= r0_e;
            r1_k  <= r0_k;
            r2_t  <= n_t;
            r2_e  <= r1_e;
        end
    end

    assign o_vld = r2_vld;
    assign o_t   = r2_t;
    assign o_e   = r2_e;

endmodule

// ===== sv/tbv_cross.sv =====
// Cross product of the unit input and B1, two register stages.
`timescale 1ns / 1ps

module tbv_cross (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbv_pkg::t_flow     i_flow,
    input  logic [2:0][31:0]   i_e,
    input  logic [2:0][31:0]   i_b1,
    output logic               o_vld,
    output tbv_pkg::t_sm [2:0] o_t,
    output logic [2:0][31:0]   o_b1
);
    import tbv_pkg::*;

    logic signed [5:0][63:0] r0_p;
    logic [2:0][31:0]        r0_b1;
    logic                    r0_vld;
    logic signed [5:0][63:0] n_p;

    always_comb begin
        n_p[0] = $signed(i_e[1]) * $signed(i_b1[2]);
        n_p[1] = $signed(i_e[2]) * $signed(i_b1[1]);
        n_p[2] = $signed(i_e[2]) * $signed(i_b1[0]);
        n_p[3] = $signed(i_e[0]) * $signed(i_b1[2]);
        n_p[4] = $signed(i_e[0]) * $signed(i_b1[1]);
        n_p[5] = $signed(i_e[1]) * $signed(i_b1[0]);
    end

    t_sm [2:0]        r1_t;
    logic [2:0][31:0] r1_b1;
    logic             r1_vld;
    t_sm [2:0]        n_t;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i] = round_q30(r0_p[2*i] - r0_p[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else if (i_flow.en) begin
            r0_vld <= i_flow.vld;
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            r0_p  <= n_p;
            r0_b1 <= i_b1;
            r1_t  <= n_t;
            r1_b1 <= r0_b1;
        end
    end

    assign o_vld = r1_vld;
    assign o_t   = r1_t;
    assign o_b1  = r1_b1;

endmodule

// ===== sv/tangent_basis_from_vector_unit.sv =====
// Top level of the tangent basis unit: input normalizer, basis stages, output register.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_data (in_x, in_y, in_z, Q16.16)
//  output    out        o_valid / i_stall    o_data (b1_*, b2_*, Q2.30)
//
// One beat is accepted per cycle and one result beat leaves per cycle while the output is not stalled.
// The pipeline is three normalizers of 70 stages each (32-stage square root
// plus 31-stage divider dominate), three Gram-Schmidt stages, two cross
// product stages and the output register.
// Reset is synchronous and active low; it clears only the valid bits.
// A stall on the output freezes the whole pipeline in place, so o_stall
// follows i_stall whenever a result beat is waiting.

module tangent_basis_from_vector_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tbv_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output tbv_pkg::t_out o_data
);
    import tbv_pkg::*;

    // Output register; it holds its beat while the receiver stalls.
    logic r_out_vld;
    t_out r_out;

    // The pipeline moves whenever the output register is free or being drained.
    logic  en;
    t_flow in_flow;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;
    assign in_flow = '{en: en, vld: i_valid};

    // Split the input into sign and magnitude. An all-zero vector is replaced
    // by the x axis before normalizing, so E is always a unit vector.
    t_sm [2:0]        in_sm;
    logic [2:0][31:0] in_raw;
    logic             in_zero;

    always_comb begin
        in_raw  = {i_data.in_x, i_data.in_y, i_data.in_z};
        in_zero = (in_raw == '0);
        for (int i = 0; i < 3; i++) begin
            in_sm[i].neg = in_raw[2-i][31];
            in_sm[i].mag = in_raw[2-i][31] ? (~in_raw[2-i] + 32'd1) : in_raw[2-i];
        end
        if (in_zero) begin
            in_sm[0].mag = Q30_ONE_U;
        end
    end

    // E: the unit input.
    logic             e_vld;
    logic [2:0][31:0] e_u;

    tbv_unitize #(
        .TAG_W (1)
    ) u_norm_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (in_flow),
        .i_v     (in_sm),
        .i_tag   (1'b0),
        .o_vld   (e_vld),
        .o_u     (e_u),
        .o_tag   ()
    );

    // B1 before normalizing: helper - (helper . E) E.
    logic             gs_vld;
    t_sm [2:0]        gs_t;
    logic [2:0][31:0] gs_e;

    tbv_gs u_gs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{en: en, vld: e_vld}),
        .i_e     (e_u),
        .o_vld   (gs_vld),
        .o_t     (gs_t),
        .o_e     (gs_e)
    );

    // B1, with E riding along as a tag.
    logic             b1_vld;
    logic [2:0][31:0] b1_u;
    logic [VEC_W-1:0] b1_e;

    tbv_unitize #(
        .TAG_W (VEC_W)
    ) u_norm_b1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{en: en, vld: gs_vld}),
        .i_v     (gs_t),
        .i_tag   (gs_e),
        .o_vld   (b1_vld),
        .o_u     (b1_u),
        .o_tag   (b1_e)
    );

    // B2 before normalizing: E x B1.
    logic             cr_vld;
    t_sm [2:0]        cr_t;
    logic [2:0][31:0] cr_b1;

    tbv_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{en: en, vld: b1_vld}),
        .i_e     (b1_e),
        .i_b1    (b1_u),
        .o_vld   (cr_vld),
        .o_t     (cr_t),
        .o_b1    (cr_b1)
    );

    // B2, with B1 riding along as a tag.
    logic             b2_vld;
    logic [2:0][31:0] b2_u;
    logic [2:0][31:0] b2_b1;

    tbv_unitize #(
        .TAG_W (VEC_W)
    ) u_norm_b2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{en: en, vld: cr_vld}),
        .i_v     (cr_t),
        .i_tag   (cr_b1),
        .o_vld   (b2_vld),
        .o_u     (b2_u),
        .o_tag   (b2_b1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= b2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.b1_x <= b2_b1[0];
            r_out.b1_y <= b2_b1[1];
            r_out.b1_z <= b2_b1[2];
            r_out.b2_x <= b2_u[0];
            r_out.b2_y <= b2_u[1];
            r_out.b2_z <= b2_u[2];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Every delivered component is limited to a magnitude of one.
    a_b1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.b1_x <= Q30_ONE_S && r_out.b1_x >= -Q30_ONE_S &&
                       r_out.b1_y <= Q30_ONE_S && r_out.b1_y >= -Q30_ONE_S &&
                       r_out.b1_z <= Q30_ONE_S && r_out.b1_z >= -Q30_ONE_S))
        else $error("B1 component out of range");

    a_b2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.b2_x <= Q30_ONE_S && r_out.b2_x >= -Q30_ONE_S &&
                       r_out.b2_y <= Q30_ONE_S && r_out.b2_y >= -Q30_ONE_S &&
                       r_out.b2_z <= Q30_ONE_S && r_out.b2_z >= -Q30_ONE_S))
        else $error("B2 component out of range");

    // While the pipeline is frozen, the last normalizer's beat is not lost.
    a_hold_b2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(b2_vld) && $stable(b2_u))
        else $error("Pipeline moved during a stall");

endmodule
